// ===== sv/hntlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hntlp_pkg: shared types and constants for the hashed name table
// Status codes, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hntlp_pkg;

  localparam int unsigned HASH_BITS     = 32;
  localparam logic [31:0] HASH_SEED     = 32'd5381;
  localparam int unsigned SLOT_BITS     = 9;   // width of the slot count register
  localparam int unsigned DIV_CNT_BITS  = 5;   // one quotient bit per step, 32 steps
  localparam int unsigned OUT_HND_BITS  = 16;
  localparam int unsigned OUT_SLOT_BITS = 8;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_NULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    load;           // input word accepted
    logic    clr_en;         // clearing sweep writes one slot
    logic    div_step;       // one remainder step
    logic    rd_en;          // read both stores at the probe slot
    logic    wr_key;         // write the key hash at the probe slot
    logic    wr_hnd;         // write the handle at the probe slot
    logic    advance;        // step to the next slot with wrap
    logic    res_set;        // capture a result
    logic    res_use_handle;
    logic    res_use_slot;
    status_t res_code;
    logic    out_load;       // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic null_op;           // register with a null handle
    logic op_lookup;
    logic clr_done;
    logic div_last;
    logic slot_empty;
    logic key_match;
    logic probe_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/hashed_name_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// hashed_name_table_linear_probe: name hash table with linear probing
// Folds name bytes into a DJB2 hash and registers or looks up the hash in an
// open-addressing table, returning one status word per name.
// ----------------------------------------------------------------------------
// Sequence: a byte that is not last is accepted and yields no word. A last byte
// holds the input through 32 serial remainder steps, a registered store read
// then compare for each probed slot, and the load of the output word, plus any
// wait while the previous word waits for out_tready. A register with a null handle
// skips the remainder and probe steps. Throughput: one name is in work at a time.
// Reset: synchronous, active low; the handle store is then cleared slot by slot.
module hashed_name_table_linear_probe #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Name byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // name_byte [7:0], sprite_handle [23:8]
  input  logic        in_tlast,   // name_last
  input  logic [0:0]  in_tuser,   // action [0]: 0 register, 1 look up
  // Result stream, one word per name.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // found_handle [15:0], slot_index [23:16]
  output logic [2:0]  out_tuser,  // status [2:0]
  // Slot count in use.
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata   // slots_in_use [8:0], upper bits ignored
);
  import hntlp_pkg::*;

  // The controller only steers; every register of payload lives in the
  // datapath, including the single-word output register, so a finished
  // result can wait downstream while the next name's bytes come in.
  // While the clearing sweep runs, in_tready stays low.
  cmd_t cmd;
  sts_t sts;

  hntlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The home slot is the hash modulo the slot count in use, computed by a
  // restoring remainder unit; probing then walks forward with wrap.
  hntlp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

endmodule

// ===== sv/hntlp_dp.sv =====
// ----------------------------------------------------------------------------
// hntlp_dp: datapath of the hashed name table
// Hash folding, bit-serial remainder unit, probe pointer, the key and handle
// stores, and the output register.
// ----------------------------------------------------------------------------
module hntlp_dp #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hntlp_pkg::cmd_t     cmd,
  output hntlp_pkg::sts_t     sts,
  input  logic [23:0]         in_tdata,
  input  logic                in_tlast,
  input  logic [0:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,
  output logic [2:0]          out_tuser,
  input  logic                cfg_tvalid,
  output logic                cfg_tready,
  input  logic [15:0]         cfg_tdata
);
  import hntlp_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [SLOT_BITS-1:0]    slots_r;
  logic [SLOT_BITS-1:0]    n;
  logic [HASH_BITS-1:0]    hash_r, hash_upd, hash_fold, key_r, div_q_r;
  logic [SLOT_BITS-1:0]    rem_r, rem_step;
  logic [SLOT_BITS:0]      div_t;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic [SLOT_BITS-1:0]    idx_r, cnt_r;
  logic [SLOT_BITS:0]      idx_inc;
  logic                    op_r;
  logic [HANDLE_BITS-1:0]  hnd_r, in_hnd;
  logic [7:0]              in_byte;
  logic [IW-1:0]           clr_r, prb_addr, hw_addr;
  logic [HANDLE_BITS-1:0]  hw_data;
  logic [HASH_BITS-1:0]    key_mem [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0]  hnd_mem [TABLE_DEPTH];
  logic [HASH_BITS-1:0]    rd_key_r;
  logic [HANDLE_BITS-1:0]  rd_hnd_r;
  status_t                 res_status_r;
  logic [OUT_HND_BITS-1:0] res_handle_r;
  logic [OUT_SLOT_BITS-1:0] res_slot_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [OUT_HND_BITS-1:0] out_handle_r;
  logic [OUT_SLOT_BITS-1:0] out_slot_r;

  // Configuration register: the slot count in use.
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOT_BITS'(256);
    end else if (cfg_tvalid) begin
      slots_r <= cfg_tdata[SLOT_BITS-1:0];
    end
  end

  // A count of zero acts as one; a count above the depth acts as the depth.
  always_comb begin
    if (slots_r == '0) begin
      n = SLOT_BITS'(1);
    end else if (32'(slots_r) > TABLE_DEPTH) begin
      n = SLOT_BITS'(TABLE_DEPTH);
    end else begin
      n = slots_r;
    end
  end

  assign in_byte   = in_tdata[7:0];
  assign in_hnd    = HANDLE_BITS'(in_tdata[23:8]);
  assign hash_upd  = (hash_r << 5) + hash_r + {24'd0, in_byte};
  assign hash_fold = (in_byte != 8'd0) ? hash_upd : hash_r;

  // Restoring remainder step: bring in one key bit, subtract the size if it fits.
  assign div_t    = {rem_r, div_q_r[HASH_BITS-1]};
  assign rem_step = (div_t >= {1'b0, n}) ? SLOT_BITS'(div_t - {1'b0, n})
                                         : div_t[SLOT_BITS-1:0];
  assign idx_inc  = {1'b0, idx_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_SEED;
    end else if (cmd.load) begin
      hash_r <= in_tlast ? HASH_SEED : hash_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_tlast) begin
      key_r     <= hash_fold;
      div_q_r   <= hash_fold;
      rem_r     <= '0;
      div_cnt_r <= '0;
      op_r      <= in_tuser[0];
      hnd_r     <= in_hnd;
    end else if (cmd.div_step) begin
      div_q_r   <= div_q_r << 1;
      rem_r     <= rem_step;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.div_step && sts.div_last) begin
      idx_r <= rem_step;
      cnt_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= (idx_inc == {1'b0, n}) ? '0 : idx_inc[SLOT_BITS-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Clearing sweep pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Table stores. An empty slot is one whose handle is zero, so only the
  // handle store needs the clearing sweep.
  assign prb_addr = IW'(idx_r);
  assign hw_addr  = cmd.clr_en ? clr_r : prb_addr;
  assign hw_data  = cmd.clr_en ? '0 : hnd_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_en || cmd.wr_hnd) begin
      hnd_mem[hw_addr] <= hw_data;
    end
    if (cmd.wr_key) begin
      key_mem[prb_addr] <= key_r;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[prb_addr];
      rd_hnd_r <= hnd_mem[prb_addr];
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_handle_r <= cmd.res_use_handle ? OUT_HND_BITS'(rd_hnd_r) : '0;
      res_slot_r   <= cmd.res_use_slot ? idx_r[OUT_SLOT_BITS-1:0] : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_slot_r, out_handle_r};
  assign out_tuser  = out_status_r;

  always_comb begin
    sts.in_last    = in_tlast;
    sts.null_op    = !in_tuser[0] && (in_hnd == '0);
    sts.op_lookup  = op_r;
    sts.clr_done   = (clr_r == IW'(TABLE_DEPTH - 1));
    sts.div_last   = (div_cnt_r == DIV_CNT_BITS'(HASH_BITS - 1));
    sts.slot_empty = (rd_hnd_r == '0);
    sts.key_match  = (rd_key_r == key_r);
    sts.probe_last = (cnt_r == n - 1'b1);
    sts.out_free   = !out_valid_r || out_tready;
  end

`ifndef ASSERT_OFF
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (idx_r < n))
    else $error("probe slot outside the slots in use");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !cmd.wr_hnd && !cmd.load)
    else $error("table access during clearing sweep");
`endif

endmodule

// ===== sv/hntlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hntlp_ctrl: controller of the hashed name table
// Sequences the clearing sweep, byte intake, remainder steps, probe walk and
// result hand-off.
// ----------------------------------------------------------------------------
module hntlp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  hntlp_pkg::sts_t sts,
  output hntlp_pkg::cmd_t cmd
);
  import hntlp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && sts.in_last) begin
          state_nxt = sts.null_op ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.slot_empty || sts.key_match || sts.probe_last) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_INSERTED;
    in_tready    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && sts.in_last && sts.null_op) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NULL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_CHK: begin
        if (sts.slot_empty) begin
          cmd.res_set = 1'b1;
          if (sts.op_lookup) begin
            cmd.res_code = ST_NOT_FOUND;
          end else begin
            cmd.wr_key       = 1'b1;
            cmd.wr_hnd       = 1'b1;
            cmd.res_use_slot = 1'b1;
            cmd.res_code     = ST_INSERTED;
          end
        end else if (sts.key_match) begin
          cmd.res_set      = 1'b1;
          cmd.res_use_slot = 1'b1;
          if (sts.op_lookup) begin
            cmd.res_use_handle = 1'b1;
            cmd.res_code       = ST_FOUND;
          end else begin
            cmd.wr_hnd   = 1'b1;
            cmd.res_code = ST_UPDATED;
          end
        end else if (sts.probe_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts.op_lookup ? ST_NOT_FOUND : ST_FULL;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd.res_code = ST_INSERTED;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken word");
  a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_key |-> (cmd.wr_hnd && !sts.op_lookup))
    else $error("key written without handle or during lookup");
  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && !sts.div_last |=> (state_r == S_DIV))
    else $error("remainder unit left before its last step");
`endif

endmodule
